// ----- hdl/ecpe_pkg.sv -----
// shared types and constants of the event camera pixel event block
package ecpe_pkg;

	localparam int X_W        = 9;
	localparam int Y_W        = 9;
	localparam int LVL_W      = 20;
	localparam int TIME_W     = 48;
	localparam int THR_W      = 19;
	localparam int REFR_W     = 32;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CUR_W      = LVL_W + 2;
	localparam int ADDR_W     = X_W + Y_W;
	localparam int PROD_W     = LVL_W + TIME_W;
	localparam int MAX_CROSSINGS = 64;
	localparam int CNT_W      = $clog2(MAX_CROSSINGS + 1);
	localparam int DCNT_W     = $clog2(PROD_W + 1);

	localparam logic [THR_W-1:0]  POS_THR_RESET = THR_W'(307);
	localparam logic [THR_W-1:0]  NEG_THR_RESET = THR_W'(307);
	localparam logic [REFR_W-1:0] REFR_RESET    = '0;

	localparam logic [CFG_IDX_W-1:0] CFG_POS_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEG_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REFR    = 2'd2;

	typedef struct packed {
		logic [X_W-1:0]           pix_x;
		logic [Y_W-1:0]           pix_y;
		logic signed [LVL_W-1:0]  level;
		logic [TIME_W-1:0]        frame_time_ns;
		logic                     frame_end;
	} pix_item_t;

	typedef struct packed {
		logic [X_W-1:0]    ev_x;
		logic [Y_W-1:0]    ev_y;
		logic [TIME_W-1:0] ev_time_ns;
		logic              ev_positive;
		logic              run_last;
	} ev_item_t;

	typedef struct packed {
		logic signed [LVL_W-1:0] prev;
		logic signed [LVL_W-1:0] ref_lvl;
		logic [TIME_W-1:0]       last;
	} pix_state_t;

endpackage

// ----- hdl/ecpe_muldiv.sv -----
// shared shift-add multiplier and restoring divider for timestamp scaling
module ecpe_muldiv import ecpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [LVL_W-1:0]  num,
	input  logic [TIME_W-1:0] delta,
	input  logic [LVL_W-1:0]  den,
	output logic              done,
	output logic [TIME_W-1:0] quot
);

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_t;

	mstate_t             state_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]   acc_q;
	logic [LVL_W-1:0]    mpl_q;
	logic [TIME_W-1:0]   delta_q;
	logic [LVL_W-1:0]    den_q;
	logic [LVL_W-1:0]    rem_q;
	logic                done_q;

	logic [LVL_W:0]      rem_sh;
	logic [PROD_W:0]     opa;
	logic [PROD_W:0]     opb;
	logic                cin;
	logic [PROD_W:0]     sum;
	logic                geq;

	// one adder serves both phases
	always_comb begin
		rem_sh = {rem_q, acc_q[PROD_W-1]};
		if (state_q == M_DIV) begin
			opa = {{(PROD_W-LVL_W){1'b0}}, rem_sh};
			opb = ~{{(PROD_W-LVL_W+1){1'b0}}, den_q};
			cin = 1'b1;
		end else begin
			opa = {1'b0, acc_q[PROD_W-2:0], 1'b0};
			opb = mpl_q[LVL_W-1] ? {{(PROD_W-TIME_W+1){1'b0}}, delta_q} : '0;
			cin = 1'b0;
		end
		sum = opa + opb + {{PROD_W{1'b0}}, cin};
		geq = ~sum[PROD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == M_DIV) && (cnt_q == DCNT_W'(PROD_W - 1));
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						acc_q   <= '0;
						mpl_q   <= num;
						delta_q <= delta;
						den_q   <= den;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					acc_q <= sum[PROD_W-1:0];
					mpl_q <= {mpl_q[LVL_W-2:0], 1'b0};
					if (cnt_q == DCNT_W'(LVL_W - 1)) begin
						cnt_q   <= '0;
						state_q <= M_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				M_DIV: begin
					rem_q <= geq ? sum[LVL_W-1:0] : rem_sh[LVL_W-1:0];
					acc_q <= {acc_q[PROD_W-2:0], geq};
					if (cnt_q == DCNT_W'(PROD_W - 1)) begin
						state_q <= M_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quot = acc_q[TIME_W-1:0];

endmodule

// ----- hdl/ecpe_pixmem.sv -----
// per-pixel state memory with registered read
module ecpe_pixmem import ecpe_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  pix_state_t        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output pix_state_t        rdata
);

	pix_state_t mem_q [2**ADDR_W];
	pix_state_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/event_camera_pixel_events_top.sv -----
// top level: pixel sequencer for contrast threshold events
//
// Pixels come in on the pix channel (valid/ready), events leave on the ev
// channel (valid/ready). Thresholds and the refractory time are written
// through cfg_we/cfg_index/cfg_data, by the user only while the block is idle; the block itself does not check this.
// Until the first pixel with frame_end, each pixel only stores its state and
// the block takes one pixel per cycle. After that, each pixel reads its stored
// state and, if its level changed, steps through its threshold crossings:
// every crossing runs one multiply and one divide on the shared unit that
// scales its timestamp into the frame interval. Up to 64 crossings are
// handled per pixel. pix_ready is low while a pixel is being worked on.
// The last found event is held back one step so that it can be marked
// run_last; an output register keeps events for the receiver, and when it
// stalls the sequencer waits with the next event. Reset clears the
// configuration to its defaults, the frame start time and the first-frame
// flag; the pixel state memory has no reset and is filled by the first frame.
module event_camera_pixel_events_top import ecpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  pix_item_t            pix,
	output logic                 ev_valid,
	input  logic                 ev_ready,
	output ev_item_t             ev,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_STEP, S_CALC, S_EVAL, S_FIN} state_t;

	state_t                  state_q;
	logic [THR_W-1:0]        pos_thr_q;
	logic [THR_W-1:0]        neg_thr_q;
	logic [REFR_W-1:0]       refr_q;
	logic [TIME_W-1:0]       fst_q;
	logic                    primed_q;
	pix_item_t               item_q;
	logic signed [LVL_W-1:0] prev_q;
	logic signed [LVL_W-1:0] ref_q;
	logic [TIME_W-1:0]       last_q;
	logic signed [CUR_W-1:0] cur_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    pos_q;
	logic [LVL_W-1:0]        den_q;
	logic [TIME_W-1:0]       delta_q;
	logic [TIME_W-1:0]       t_q;
	logic                    pend_valid_q;
	ev_item_t                pend_q;
	logic                    ev_valid_q;
	ev_item_t                ev_q;

	pix_state_t              rd;
	pix_state_t              wdata;
	logic                    we;
	logic [ADDR_W-1:0]       waddr;
	logic                    md_start;
	logic                    md_done;
	logic [TIME_W-1:0]       md_quot;

	logic                    pix_xfer;
	logic signed [CUR_W-1:0] step;
	logic signed [CUR_W-1:0] cur_n;
	logic signed [CUR_W-1:0] prev_ext;
	logic signed [CUR_W-1:0] lvl_ext;
	logic signed [CUR_W-1:0] num_s;
	logic                    in_iv;
	logic                    ge;
	logic                    ok;
	logic [TIME_W-1:0]       gap;
	logic                    out_free;
	logic signed [CUR_W-1:0] diff_rd;
	logic                    ev_load;

	assign pix_ready = (state_q == S_IDLE);
	assign pix_xfer  = pix_valid && pix_ready;
	assign out_free  = !ev_valid_q || ev_ready;

	always_comb begin
		step     = pos_q ? CUR_W'({1'b0, pos_thr_q}) : -CUR_W'({1'b0, neg_thr_q});
		cur_n    = cur_q + step;
		prev_ext = CUR_W'(prev_q);
		lvl_ext  = CUR_W'(item_q.level);
		in_iv    = pos_q ? (cur_n > prev_ext && cur_n <= lvl_ext)
		                 : (cur_n < prev_ext && cur_n >= lvl_ext);
		num_s    = pos_q ? (cur_n - prev_ext) : (prev_ext - cur_n);
		gap      = t_q - last_q;
		ge       = t_q >= last_q;
		ok       = (last_q == '0) || (gap >= {{(TIME_W-REFR_W){1'b0}}, refr_q});
		diff_rd  = CUR_W'(item_q.level) - CUR_W'(rd.prev);
		md_start = (state_q == S_STEP) && (cnt_q < CNT_W'(MAX_CROSSINGS)) && in_iv;
		ev_load  = pend_valid_q && out_free
		           && ((state_q == S_EVAL && ge && ok) || state_q == S_FIN);
	end

	// state memory write: first frame at accept, otherwise on finish
	always_comb begin
		we    = 1'b0;
		waddr = {item_q.pix_y, item_q.pix_x};
		wdata = '{prev: item_q.level, ref_lvl: ref_q, last: last_q};
		if (pix_xfer && !primed_q) begin
			we    = 1'b1;
			waddr = {pix.pix_y, pix.pix_x};
			wdata = '{prev: pix.level, ref_lvl: pix.level, last: '0};
		end else if (state_q == S_FIN && (!pend_valid_q || out_free)) begin
			we = 1'b1;
		end
	end

	ecpe_pixmem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr ({pix.pix_y, pix.pix_x}),
		.rdata (rd)
	);

	ecpe_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.num    (num_s[LVL_W-1:0]),
		.delta  (delta_q),
		.den    (den_q),
		.done   (md_done),
		.quot   (md_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pos_thr_q    <= POS_THR_RESET;
			neg_thr_q    <= NEG_THR_RESET;
			refr_q       <= REFR_RESET;
			fst_q        <= '0;
			primed_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			ev_valid_q   <= 1'b0;
		end else begin
			ev_valid_q <= ev_load || (ev_valid_q && !ev_ready);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POS_THR: pos_thr_q <= cfg_data[THR_W-1:0];
					CFG_NEG_THR: neg_thr_q <= cfg_data[THR_W-1:0];
					CFG_REFR:    refr_q    <= cfg_data[REFR_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (pix_xfer) begin
						item_q <= pix;
						if (!primed_q) begin
							if (pix.frame_end) begin
								fst_q    <= pix.frame_time_ns;
								primed_q <= 1'b1;
							end
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					prev_q  <= rd.prev;
					ref_q   <= rd.ref_lvl;
					last_q  <= rd.last;
					cur_q   <= CUR_W'(rd.ref_lvl);
					cnt_q   <= '0;
					pos_q   <= !diff_rd[CUR_W-1];
					den_q   <= diff_rd[CUR_W-1] ? LVL_W'(-diff_rd) : LVL_W'(diff_rd);
					delta_q <= item_q.frame_time_ns - fst_q;
					state_q <= (diff_rd == '0) ? S_FIN : S_STEP;
				end
				S_STEP: begin
					if (md_start) begin
						cur_q   <= cur_n;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_CALC;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_CALC: begin
					if (md_done) begin
						t_q     <= fst_q + md_quot;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!ge) begin
						state_q <= S_STEP;
					end else if (!ok) begin
						ref_q   <= cur_q[LVL_W-1:0];
						state_q <= S_STEP;
					end else if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							ev_q <= pend_q;
						end
						pend_q       <= '{ev_x: item_q.pix_x, ev_y: item_q.pix_y,
						                  ev_time_ns: t_q, ev_positive: pos_q,
						                  run_last: 1'b0};
						pend_valid_q <= 1'b1;
						last_q       <= t_q;
						ref_q        <= cur_q[LVL_W-1:0];
						state_q      <= S_STEP;
					end
				end
				S_FIN: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							ev_q <= '{ev_x: pend_q.ev_x, ev_y: pend_q.ev_y,
							          ev_time_ns: pend_q.ev_time_ns,
							          ev_positive: pend_q.ev_positive,
							          run_last: 1'b1};
						end
						pend_valid_q <= 1'b0;
						if (item_q.frame_end) begin
							fst_q    <= item_q.frame_time_ns;
							primed_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ev_valid = ev_valid_q;
	assign ev       = ev_q;

endmodule

// ----- hdl/ecpe_checker.sv -----
// port-level checks of the pixel event block, bound to the top level
module ecpe_checker import ecpe_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pix_valid,
	input logic                 pix_ready,
	input logic                 ev_valid,
	input logic                 ev_ready,
	input ev_item_t             ev
);

	// a stalled event holds
	assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_ready |=> ev_valid && $stable(ev))
		else $error("event changed while stalled");

	// an event that is not the last of its run means the pixel is still busy
	assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev.run_last |-> !pix_ready)
		else $error("ready while a run is open");

	// ready only drops after a pixel transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pix_ready) |-> $past(pix_valid))
		else $error("ready dropped without transfer");

	// a new event appears only while busy or right after finishing
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ev_valid) |-> !$past(pix_ready))
		else $error("event out of an idle block");

endmodule

bind event_camera_pixel_events_top ecpe_checker u_chk (.*);

// ----- dv/event_camera_pixel_events_top_tb.sv -----
// testbench for the event camera pixel event block: predicts events per pixel and checks them
`timescale 1ns / 100ps

module event_camera_pixel_events_top_tb;
	import ecpe_pkg::*;

	localparam int POOL_N    = 24;
	localparam int SETTLE    = 6500;
	localparam int WDOG_MAX  = 80000;
	localparam logic [LVL_W-1:0] LVL_MAX = 20'sh7FFFF;
	localparam logic [LVL_W-1:0] LVL_MIN = 20'sh80000;

	class crossing_board;
		ev_item_t                pending_ev[$];
		logic signed [LVL_W-1:0] prev_lvl[int];
		logic signed [LVL_W-1:0] ref_lvl[int];
		logic [TIME_W-1:0]       last_t[int];
		logic [TIME_W-1:0]       frame_start;
		bit                      primed;
		logic [THR_W-1:0]        pos_thr;
		logic [THR_W-1:0]        neg_thr;
		logic [REFR_W-1:0]       refr;
		int                      errors;

		function new();
			frame_start = '0;
			primed      = 0;
			pos_thr     = POS_THR_RESET;
			neg_thr     = NEG_THR_RESET;
			refr        = REFR_RESET;
			errors      = 0;
		endfunction

		function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				CFG_POS_THR: pos_thr = v[THR_W-1:0];
				CFG_NEG_THR: neg_thr = v[THR_W-1:0];
				CFG_REFR:    refr    = v[REFR_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [63:0] interp(bit [63:0] num, bit [63:0] delta, bit [63:0] den);
			return num * (delta / den) + (num * (delta % den)) / den;
		endfunction

		function void note(pix_item_t p);
			int                key;
			longint            it;
			longint            lv;
			longint            cur;
			longint            step;
			bit                pos;
			bit [TIME_W-1:0]   delta;
			bit [63:0]         den;
			bit [63:0]         num;
			bit [TIME_W-1:0]   t;
			bit [TIME_W-1:0]   last;
			int                count;
			ev_item_t          e;
			ev_item_t          run[$];
			key = {p.pix_y, p.pix_x};
			if (!primed) begin
				prev_lvl[key] = p.level;
				ref_lvl[key]  = p.level;
				last_t[key]   = '0;
			end else begin
				it = prev_lvl[key];
				lv = p.level;
				if (lv != it) begin
					pos   = lv > it;
					step  = pos ? longint'(pos_thr) : -longint'(neg_thr);
					cur   = ref_lvl[key];
					delta = p.frame_time_ns - frame_start;
					den   = pos ? lv - it : it - lv;
					count = 0;
					while (count < MAX_CROSSINGS) begin
						cur += step;
						if (pos ? !(cur > it && cur <= lv) : !(cur < it && cur >= lv))
							break;
						count++;
						num  = pos ? cur - it : it - cur;
						t    = TIME_W'(frame_start + interp(num, 64'(delta), den));
						last = last_t[key];
						if (t >= last) begin
							if (last == 0 || t - last >= 48'(refr)) begin
								e.ev_x        = p.pix_x;
								e.ev_y        = p.pix_y;
								e.ev_time_ns  = t;
								e.ev_positive = pos;
								e.run_last    = 1'b0;
								run = {run, e};
								last_t[key] = t;
							end
							ref_lvl[key] = LVL_W'(cur);
						end
					end
					if (run.size() > 0)
						run[run.size()-1].run_last = 1'b1;
					foreach (run[i])
						pending_ev = {pending_ev, run[i]};
				end
				prev_lvl[key] = p.level;
			end
			if (p.frame_end) begin
				frame_start = p.frame_time_ns;
				primed      = 1;
			end
		endfunction

		function void check(ev_item_t got);
			ev_item_t want;
			if (pending_ev.size() == 0) begin
				$error("unexpected event x=%0d y=%0d t=%0d", got.ev_x, got.ev_y, got.ev_time_ns);
				errors++;
				return;
			end
			want = pending_ev.pop_front();
			if (got.ev_x !== want.ev_x) begin
				$error("ev_x expected %0d actual %0d", want.ev_x, got.ev_x);
				errors++;
			end
			if (got.ev_y !== want.ev_y) begin
				$error("ev_y expected %0d actual %0d", want.ev_y, got.ev_y);
				errors++;
			end
			if (got.ev_time_ns !== want.ev_time_ns) begin
				$error("ev_time_ns expected %0d actual %0d", want.ev_time_ns, got.ev_time_ns);
				errors++;
			end
			if (got.ev_positive !== want.ev_positive) begin
				$error("ev_positive expected %0d actual %0d", want.ev_positive, got.ev_positive);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last expected %0d actual %0d", want.run_last, got.run_last);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 pix_valid;
	logic                 pix_ready;
	pix_item_t            pix;
	logic                 ev_valid;
	logic                 ev_ready;
	ev_item_t             ev;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	crossing_board      board;
	int                 send_idle;
	int                 recv_idle;
	int                 quiet_cycles;
	int                 pool_x[POOL_N];
	int                 pool_y[POOL_N];
	logic [TIME_W-1:0]  now_ns;

	event_camera_pixel_events_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.ev_valid  (ev_valid),
		.ev_ready  (ev_ready),
		.ev        (ev),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		ev_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && ev_valid && ev_ready)
			board.check(ev);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (ev_valid && ev_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WDOG_MAX) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_pixel(input pix_item_t item);
		while ($urandom_range(99) < send_idle) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= item;
		do @(posedge clk); while (!pix_ready);
		board.note(item);
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_ev.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (!pix_ready) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_W-1:0] pthr, input logic [CFG_W-1:0] nthr,
		input logic [CFG_W-1:0] refr);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_POS_THR;
		cfg_data  <= pthr;
		@(posedge clk);
		board.set_cfg(CFG_POS_THR, pthr);
		cfg_index <= CFG_NEG_THR;
		cfg_data  <= nthr;
		@(posedge clk);
		board.set_cfg(CFG_NEG_THR, nthr);
		cfg_index <= CFG_REFR;
		cfg_data  <= refr;
		@(posedge clk);
		board.set_cfg(CFG_REFR, refr);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic pix_item_t make_pix(int slot, logic [LVL_W-1:0] lvl, bit fend);
		pix_item_t p;
		p.pix_x         = X_W'(pool_x[slot]);
		p.pix_y         = Y_W'(pool_y[slot]);
		p.level         = lvl;
		p.frame_time_ns = now_ns;
		p.frame_end     = fend;
		return p;
	endfunction

	// mostly a few threshold steps away from the last level, sometimes anything
	function automatic logic [LVL_W-1:0] next_level(int slot);
		longint base;
		longint thr;
		longint d;
		base = board.prev_lvl[{9'(pool_y[slot]), 9'(pool_x[slot])}];
		if ($urandom_range(9) == 0)
			return LVL_W'($urandom);
		if ($urandom_range(1)) begin
			thr = board.pos_thr;
			d = thr * $urandom_range(4) + $urandom_range(thr - 1);
		end else begin
			thr = board.neg_thr;
			d = -(thr * $urandom_range(4) + $urandom_range(thr - 1));
		end
		base += d;
		if (base > 524287) base = 524287;
		if (base < -524288) base = -524288;
		return LVL_W'(base);
	endfunction

	task automatic random_frames(input int n_items);
		int left;
		int len;
		left = n_items;
		while (left > 0) begin
			len = $urandom_range(1, 8);
			if ($urandom_range(19) == 0)
				now_ns = TIME_W'({$urandom, $urandom});
			else
				now_ns = now_ns + $urandom_range(1, 1 << 20);
			for (int i = 0; i < len; i++) begin
				int slot;
				slot = $urandom_range(POOL_N - 1);
				send_pixel(make_pix(slot, next_level(slot), i == len - 1));
			end
			left -= len;
		end
	endtask

	initial begin
		board        = new();
		arst_n       = 1'b0;
		pix_valid    = 1'b0;
		pix          = '0;
		ev_ready     = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_POS_THR;
		cfg_data     = '0;
		quiet_cycles = 0;
		send_idle    = 14;
		recv_idle    = 54;
		pool_x[0] = 0;   pool_y[0] = 0;
		pool_x[1] = 511; pool_y[1] = 511;
		pool_x[2] = 511; pool_y[2] = 0;
		pool_x[3] = 0;   pool_y[3] = 511;
		for (int i = 4; i < POOL_N; i++) begin
			pool_x[i] = $urandom_range(511);
			pool_y[i] = $urandom_range(511);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first frame only stores state
		now_ns = 48'(1000 + $urandom_range(100000));
		for (int i = 0; i < POOL_N; i++)
			send_pixel(make_pix(i, (i % 2) ? LVL_MIN : LVL_W'($urandom), i == POOL_N - 1));

		// directed with reset thresholds: full swings, no change, small change
		now_ns = now_ns + 48'd1_000_000;
		send_pixel(make_pix(0, LVL_MAX, 0));
		send_pixel(make_pix(1, LVL_MAX, 0));
		send_pixel(make_pix(1, LVL_MAX, 0));
		send_pixel(make_pix(0, LVL_MIN, 0));
		send_pixel(make_pix(2, LVL_W'(board.prev_lvl[{9'd0, 9'd511}] + 1), 0));
		send_pixel(make_pix(4, LVL_W'(0), 0));
		send_pixel(make_pix(5, LVL_W'(700), 1));
		now_ns = now_ns - 48'd500_000;
		send_pixel(make_pix(5, LVL_W'(-700), 0));
		send_pixel(make_pix(4, LVL_W'(2000), 1));
		now_ns = now_ns + 48'd3_000_000;
		send_pixel(make_pix(3, LVL_MAX, 1));
		drain();

		write_cfg(10, 10, 0);
		now_ns = now_ns + 48'd1_000;
		send_pixel(make_pix(6, LVL_W'(board.prev_lvl[{9'(pool_y[6]), 9'(pool_x[6])}] + 25), 1));
		random_frames(80);
		drain();

		send_idle = 54;
		recv_idle = 14;
		write_cfg(524287, 524287, 32'hFFFF_FFFF);
		now_ns = now_ns + 48'd1_000;
		send_pixel(make_pix(1, LVL_MIN, 0));
		send_pixel(make_pix(1, LVL_MAX, 1));
		random_frames(70);
		drain();

		write_cfg($urandom_range(10, 3000), $urandom_range(10, 3000),
			$urandom_range(0, 300000));
		random_frames(80);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_cfg(307, $urandom_range(10, 524287), 1000);
		random_frames(80);
		drain();

		if (board.errors == 0 && board.pending_ev.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/ecpe_pkg.sv
hdl/ecpe_muldiv.sv
hdl/ecpe_pixmem.sv
hdl/event_camera_pixel_events_top.sv
hdl/ecpe_checker.sv
dv/event_camera_pixel_events_top_tb.sv
